// ===== rtl/ihm_pkg.sv =====
// ----------------------------------------------------------------------------
// ihm_pkg: shared types and constants for the integer key hash map
// Operation and status codes, the slot layout, controller commands and the
// key mixing rounds.
// ----------------------------------------------------------------------------
package ihm_pkg;

    localparam int KEY_W       = 64;
    localparam int VAL_W       = 64;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 3;
    localparam int COUNT_OUT_W = 11;
    localparam int HASH_W      = 32;

    // operation codes
    localparam logic [REQ_W-1:0] REQ_SET = 2'd0;
    localparam logic [REQ_W-1:0] REQ_GET = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DEL = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd5;

    // mix shift amounts
    localparam int SH_A = 21;
    localparam int SH_B = 24;
    localparam int SH_C = 3;
    localparam int SH_D = 8;
    localparam int SH_E = 14;
    localparam int SH_F = 2;
    localparam int SH_G = 4;
    localparam int SH_H = 28;
    localparam int SH_I = 31;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } slot_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // latch request, first mix round
        logic hash2;    // second mix round
        logic hash3;    // third mix round
        logic read;     // fetch bucket row
        logic exec;     // compare ways, write back, load result
        logic clear;    // write an empty row during the clearing pass
    } ihm_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
    } ihm_stat_t;

    function automatic logic [KEY_W-1:0] mix_round1(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] t;
        t = ~k + (k << SH_A);
        return t ^ (t >> SH_B);
    endfunction

    function automatic logic [KEY_W-1:0] mix_round2(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] t;
        t = (k + (k << SH_C)) + (k << SH_D);
        return t ^ (t >> SH_E);
    endfunction

    function automatic logic [KEY_W-1:0] mix_round3(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] t;
        t = (k + (k << SH_F)) + (k << SH_G);
        return t ^ (t >> SH_H);
    endfunction

    // only the low 32 bits of the last round are kept
    function automatic logic [HASH_W-1:0] mix_final(input logic [KEY_W-1:0] k);
        logic [HASH_W-1:0] t;
        t = k[HASH_W-1:0];
        return t + (t << SH_I);
    endfunction

endpackage

// ===== rtl/int_key_hash_map.sv =====
// ----------------------------------------------------------------------------
// int_key_hash_map: set-associative map from 64-bit keys to 64-bit values
// Set, get and delete on a bucketed table addressed by a 64-to-32 key mix.
// ----------------------------------------------------------------------------
// Usage
//   Requests enter on the s_ stream, one transaction per request; each one
//   yields exactly one result transaction on the m_ stream, in order.
//   The key is mixed in three registered rounds (the final 32-bit add is
//   folded into the read address), the bucket row is read from the row RAM,
//   then all ways are compared at once and a changed row is written back.
//   Each request passes through the first mix round as it is accepted, the
//   second and third mix rounds, the registered row read and the
//   compare/write-back step; only one request is in flight at a time, so
//   the next is not accepted until the older one has passed that step.
//   The result sits in an output register; the next request is accepted and
//   processed while it waits, and only the compare/write-back step holds off
//   until m_tready has taken the older result.
//   Reset (aresetn low, synchronous) clears the entry count and the result
//   valid flag and starts a clearing pass that writes every bucket row empty;
//   s_tready stays low until it has finished.
//   A set into a bucket with no free way answers bucket full and changes
//   nothing. Operation code 3 answers not found.
// ----------------------------------------------------------------------------
module int_key_hash_map
    import ihm_pkg::*;
#(
    parameter int NUM_BUCKETS = 256,   // power of two
    parameter int BUCKET_WAYS = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    // request stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,  // [1:0] req_type, [65:2] lookup_key,
                                   // [129:66] value_in, [135:130] zero
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata   // [2:0] status, [66:3] value_out,
                                   // [77:67] entry_count, [79:78] zero
);

    ihm_cmd_t                cmd;
    ihm_stat_t               stat;
    logic [STATUS_W-1:0]     status;
    logic [VAL_W-1:0]        value_out;
    logic [COUNT_OUT_W-1:0]  entry_count;

    // sequencer: clearing pass, mix steps, read, execute, result valid
    ihm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // mix, bucket RAM, way compare, counters and result register
    ihm_dpath #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .BUCKET_WAYS (BUCKET_WAYS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .req_type    (s_tdata[1:0]),
        .lookup_key  (s_tdata[65:2]),
        .value_in    (s_tdata[129:66]),
        .status      (status),
        .value_out   (value_out),
        .entry_count (entry_count)
    );

    assign m_tdata = {2'b00, entry_count, value_out, status};

    // no request is taken while rows are being cleared
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |-> !s_tready)
        else $error("request accepted during clearing pass");

    // the result register is never overwritten while a result is still pending
    a_exec_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> (!m_tvalid || m_tready))
        else $error("pending result overwritten");

    // a result appears only right after an execute step
    a_valid_from_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.exec))
        else $error("result valid without execute");

    // an accepted request always proceeds to the second mix round
    a_accept_to_mix: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> cmd.hash2)
        else $error("accepted request not sequenced");

endmodule

// ===== rtl/ihm_ram.sv =====
// ----------------------------------------------------------------------------
// ihm_ram: generic simple dual port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ihm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/ihm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ihm_ctrl: request sequencer for the integer key hash map
// Runs the clearing pass, then steps each transaction through mix, read and
// execute; owns the result valid flag.
// ----------------------------------------------------------------------------
module ihm_ctrl
    import ihm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  ihm_stat_t stat,
    output ihm_cmd_t  cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH2 = 3'd2;
    localparam logic [2:0] S_HASH3 = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_EXEC  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       exec_ok;

    // result slot is free, or being emptied this cycle
    assign exec_ok = !out_valid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (stat.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_HASH2;
                end
            end
            S_HASH2: begin
                cmd.hash2  = 1'b1;
                state_next = S_HASH3;
            end
            S_HASH3: begin
                cmd.hash3  = 1'b1;
                state_next = S_READ;
            end
            S_READ: begin
                cmd.read   = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (exec_ok) begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

// ===== rtl/ihm_dpath.sv =====
// ----------------------------------------------------------------------------
// ihm_dpath: datapath of the integer key hash map
// Key mix registers, bucket row RAM, way compare, row update, entry count
// and the result register.
// ----------------------------------------------------------------------------
module ihm_dpath
    import ihm_pkg::*;
#(
    parameter int NUM_BUCKETS = 256,
    parameter int BUCKET_WAYS = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ihm_cmd_t               cmd,
    output ihm_stat_t              stat,
    input  logic [REQ_W-1:0]       req_type,
    input  logic [KEY_W-1:0]       lookup_key,
    input  logic [VAL_W-1:0]       value_in,
    output logic [STATUS_W-1:0]    status,
    output logic [VAL_W-1:0]       value_out,
    output logic [COUNT_OUT_W-1:0] entry_count
);

    localparam int IDX_W  = $clog2(NUM_BUCKETS);
    localparam int WAY_W  = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
    localparam int SLOT_W = $bits(slot_t);
    localparam int ROW_W  = BUCKET_WAYS * SLOT_W;
    localparam int CNT_W  = $clog2(NUM_BUCKETS * BUCKET_WAYS + 1);

    logic [REQ_W-1:0]  req_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [KEY_W-1:0]  mix_reg;
    logic [IDX_W-1:0]  bucket_reg;
    logic [IDX_W-1:0]  clr_idx_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [HASH_W-1:0] hash;
    logic [IDX_W-1:0]  bucket;

    logic [ROW_W-1:0]  rd_row;
    logic [ROW_W-1:0]  wr_row;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;

    slot_t [BUCKET_WAYS-1:0] row, row_new;
    logic                    hit_found, free_found, row_dirty;
    logic [WAY_W-1:0]        hit_way, free_way;
    logic [STATUS_W-1:0]     st_next;
    logic [VAL_W-1:0]        vout_next;

    assign hash   = mix_final(mix_reg);
    assign bucket = hash[IDX_W-1:0];

    // request and mix rounds
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= req_type;
            key_reg <= lookup_key;
            val_reg <= value_in;
            mix_reg <= mix_round1(lookup_key);
        end else if (cmd.hash2) begin
            mix_reg <= mix_round2(mix_reg);
        end else if (cmd.hash3) begin
            mix_reg <= mix_round3(mix_reg);
        end
        if (cmd.read) begin
            bucket_reg <= bucket;
        end
    end

    ihm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_BUCKETS)
    ) u_rows (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_row),
        .re    (cmd.read),
        .raddr (bucket),
        .rdata (rd_row)
    );

    assign row = rd_row;

    // way compare: lowest matching valid way, lowest free way
    always_comb begin
        hit_found  = 1'b0;
        free_found = 1'b0;
        hit_way    = '0;
        free_way   = '0;
        for (int w = 0; w < BUCKET_WAYS; w++) begin
            if (row[w].valid) begin
                if (!hit_found && row[w].key == key_reg) begin
                    hit_found = 1'b1;
                    hit_way   = WAY_W'(w);
                end
            end else if (!free_found) begin
                free_found = 1'b1;
                free_way   = WAY_W'(w);
            end
        end
    end

    always_comb begin
        row_new    = row;
        row_dirty  = 1'b0;
        count_next = count_reg;
        st_next    = ST_MISSING;
        vout_next  = '0;
        case (req_reg)
            REQ_SET: begin
                if (hit_found) begin
                    row_new[hit_way].value = val_reg;
                    row_dirty = 1'b1;
                    st_next   = ST_UPDATED;
                end else if (free_found) begin
                    row_new[free_way].valid = 1'b1;
                    row_new[free_way].key   = key_reg;
                    row_new[free_way].value = val_reg;
                    row_dirty  = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    st_next    = ST_INSERTED;
                end else begin
                    st_next = ST_FULL;
                end
            end
            REQ_GET: begin
                if (hit_found) begin
                    vout_next = row[hit_way].value;
                    st_next   = ST_FOUND;
                end
            end
            REQ_DEL: begin
                if (hit_found) begin
                    row_new[hit_way].valid = 1'b0;
                    row_dirty = 1'b1;
                    if (count_reg != '0) begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    st_next = ST_DELETED;
                end
            end
            default: begin
                st_next = ST_MISSING;
            end
        endcase
    end

    // clearing pass writes rows with every way invalid
    assign ram_we    = cmd.clear || (cmd.exec && row_dirty);
    assign ram_waddr = cmd.clear ? clr_idx_reg : bucket_reg;
    assign wr_row    = cmd.clear ? '0 : ROW_W'(row_new);

    assign stat.clear_last = (clr_idx_reg == IDX_W'(NUM_BUCKETS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg <= '0;
            count_reg   <= '0;
        end else begin
            if (cmd.clear) begin
                clr_idx_reg <= clr_idx_reg + IDX_W'(1);
            end
            if (cmd.exec) begin
                count_reg <= count_next;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status      <= st_next;
            value_out   <= vout_next;
            entry_count <= COUNT_OUT_W'(count_next);
        end
    end

endmodule
